// ===== sv/ipd_pkg.sv =====
// Shared package for the inversion-parity block.
// Sizes, the token that travels down the cell chain. No dependencies.
package ipd_pkg;

   localparam int unsigned MAX_ITEMS    = 1024;
   localparam int unsigned VALUE_W      = 32;
   localparam int unsigned INV_CNT_W    = 19;
   localparam int unsigned ITEM_CNT_W   = $clog2(MAX_ITEMS + 1);
   localparam int unsigned GREATER_W    = $clog2(MAX_ITEMS);

   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic                 placed;
      logic                 dup;
      logic                 ovf;
      logic [GREATER_W-1:0] greater;
      logic [VALUE_W-1:0]   value;
   } token_type;

endpackage

// ===== sv/ipd_cell.sv =====
// One cell of the chain: holds one earlier value and compares passing requests.
// Depends on ipd_pkg.
module ipd_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  ipd_pkg::token_type tok_in,
   output ipd_pkg::token_type tok_out
);
   import ipd_pkg::*;

   token_type            tok_ff, tok_in_next;
   logic                 held_ff, held_in;
   logic [VALUE_W-1:0]   held_value_ff, held_value_in;
   logic                 live;

   assign live = tok_in.valid && !tok_in.placed;

   always_comb begin
      tok_in_next   = tok_in;
      held_in       = held_ff;
      held_value_in = held_value_ff;
      if (live && held_ff) begin
         if ($signed(held_value_ff) > $signed(tok_in.value)) begin
            tok_in_next.greater = tok_in.greater + GREATER_W'(1);
         end else if (held_value_ff == tok_in.value) begin
            tok_in_next.dup = 1'b1;
         end
      end else if (live) begin
         tok_in_next.placed = 1'b1;
         held_in            = 1'b1;
         held_value_in      = tok_in.value;
      end
      // end of sequence empties the cell behind the final request
      if (tok_in.valid && tok_in.last) begin
         held_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         held_ff      <= 1'b0;
      end else if (advance) begin
         tok_ff        <= tok_in_next;
         held_ff       <= held_in;
         held_value_ff <= held_value_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== sv/ipd_tail.sv =====
// End of the chain: sums per-request counts and holds the result register.
// Depends on ipd_pkg.
module ipd_tail (
   input  logic                     clock,
   input  logic                     reset,
   input  ipd_pkg::token_type       tok_in,
   output logic                     advance,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_sortable,
   output logic [ipd_pkg::INV_CNT_W-1:0] rsp_inversion_count,
   output logic                     rsp_has_duplicate,
   output logic                     rsp_overflowed
);
   import ipd_pkg::*;

   logic [INV_CNT_W-1:0] total_ff, total_in, sum;
   logic                 dup_ff, dup_in, dup_sum;
   logic                 ovf_ff, ovf_in, ovf_sum;
   logic                 valid_ff, valid_in;
   logic                 sortable_ff;
   logic [INV_CNT_W-1:0] count_ff;
   logic                 has_dup_ff, ovfl_ff;
   logic                 finish;

   assign advance = !valid_ff || !rsp_stall;
   assign sum     = total_ff + {{(INV_CNT_W-GREATER_W){1'b0}}, tok_in.greater};
   assign dup_sum = dup_ff || tok_in.dup;
   assign ovf_sum = ovf_ff || tok_in.ovf;
   assign finish  = tok_in.valid && tok_in.last;

   always_comb begin
      total_in = total_ff;
      dup_in   = dup_ff;
      ovf_in   = ovf_ff;
      valid_in = valid_ff && rsp_stall;
      if (tok_in.valid) begin
         total_in = sum;
         dup_in   = dup_sum;
         ovf_in   = ovf_sum;
      end
      if (finish) begin
         total_in = '0;
         dup_in   = 1'b0;
         ovf_in   = 1'b0;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         dup_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else if (advance) begin
         total_ff <= total_in;
         dup_ff   <= dup_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && finish) begin
         sortable_ff <= dup_sum || !sum[0];
         count_ff    <= sum;
         has_dup_ff  <= dup_sum;
         ovfl_ff     <= ovf_sum;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_sortable        = sortable_ff;
   assign rsp_inversion_count = count_ff;
   assign rsp_has_duplicate   = has_dup_ff;
   assign rsp_overflowed      = ovfl_ff;

endmodule

// ===== sv/inversion_parity_with_duplicates_top.sv =====
// Inversion parity block: top level with the cell chain and result stage.
// Depends on ipd_pkg, ipd_cell, ipd_tail.
//
// Usage:
//  - Input channel req_*: one signed 32-bit value per request, req_last_item
//    marks the last value. One request is taken per cycle unless stalled.
//  - Each request walks a chain of MAX_ITEMS cells, one cell per cycle unless
//    frozen. Every cell holds one earlier value of the sequence, counts it if
//    greater and flags it if equal; the first empty cell keeps the new value.
//  - Result channel rsp_*: one response per sequence, emitted once the request
//    with req_last_item has passed every cell and is registered in the tail.
//    Unless stalled, throughput is one request per cycle, set by the cell chain.
//  - Requests beyond MAX_ITEMS in one sequence are not compared and set
//    rsp_overflowed; the response then covers the first MAX_ITEMS values.
//  - The final request empties each cell as it passes, so the next sequence
//    may follow it in the next cycle.
//  - While a response is held by rsp_stall the whole chain freezes and
//    req_stall is raised.
//  - Synchronous reset empties all cells and counters and clears rsp_valid.
module inversion_parity_with_duplicates_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [ipd_pkg::VALUE_W-1:0] req_value,
   input  logic                            req_last_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_sortable,
   output logic [ipd_pkg::INV_CNT_W-1:0]   rsp_inversion_count,
   output logic                            rsp_has_duplicate,
   output logic                            rsp_overflowed
);
   import ipd_pkg::*;

   token_type             chain [MAX_ITEMS+1];
   logic                  advance;
   logic                  full;
   logic                  accept;
   logic [ITEM_CNT_W-1:0] item_cnt_ff, item_cnt_in;

   assign full      = item_cnt_ff >= ITEM_CNT_W'(MAX_ITEMS);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   always_comb begin
      item_cnt_in = item_cnt_ff;
      if (accept && req_last_item) begin
         item_cnt_in = '0;
      end else if (accept && !full) begin
         item_cnt_in = item_cnt_ff + ITEM_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_cnt_ff <= '0;
      end else begin
         item_cnt_ff <= item_cnt_in;
      end
   end

   always_comb begin
      chain[0].valid   = req_valid;
      chain[0].last    = req_last_item;
      chain[0].placed  = full;
      chain[0].dup     = 1'b0;
      chain[0].ovf     = full;
      chain[0].greater = '0;
      chain[0].value   = req_value;
   end

   for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
      ipd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .tok_in   (chain[k]),
         .tok_out  (chain[k+1])
      );
   end

   ipd_tail u_tail (
      .clock               (clock),
      .reset               (reset),
      .tok_in              (chain[MAX_ITEMS]),
      .advance             (advance),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sortable        (rsp_sortable),
      .rsp_inversion_count (rsp_inversion_count),
      .rsp_has_duplicate   (rsp_has_duplicate),
      .rsp_overflowed      (rsp_overflowed)
   );

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      item_cnt_ff <= ITEM_CNT_W'(MAX_ITEMS))
      else $error("item count above capacity");

   a_cnt_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_item) |=> (item_cnt_ff == '0))
      else $error("item count not cleared after final request");

   a_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sortable == (rsp_has_duplicate || !rsp_inversion_count[0])))
      else $error("verdict disagrees with count parity");
`endif

endmodule

// ===== sim/inversion_parity_with_duplicates_top_tb.sv =====
// Self-checking bench for inversion_parity_with_duplicates_top: value sequences in,
// one verdict per sequence out, predicted in a scoreboard and checked field by field.
// Depends on ipd_pkg and the top level RTL with its ipd_cell and ipd_tail.
module inversion_parity_with_duplicates_top_tb;
   import ipd_pkg::*;

   localparam int VAL_MIN         = 32'sh8000_0000;
   localparam int VAL_MAX         = 32'sh7fff_ffff;
   localparam int RANDOM_REQUESTS = 730;
   localparam int QUIET_REQUESTS  = 150;

   typedef enum int {FULL_RANGE, DENSE, EXTREME, ASCENDING, DESCENDING, MIXED} value_style_type;

   typedef struct packed {
      logic                 sortable;
      logic [INV_CNT_W-1:0] inversions;
      logic                 duplicate;
      logic                 overflowed;
   } sort_verdict_type;

   class parity_scoreboard;
      int                   history [MAX_ITEMS];
      int unsigned          held;
      logic [INV_CNT_W-1:0] inversion_sum = '0;
      bit                   dup_seen;
      bit                   ovf_seen;
      sort_verdict_type     verdict_q [$];
      int unsigned          errors;
      int unsigned          requests;
      int unsigned          responses;
      int unsigned          dup_runs;

      function void note_request(int v, bit last);
         int unsigned      greater;
         sort_verdict_type exp_v;
         greater = 0;
         requests++;
         if (held < MAX_ITEMS) begin
            for (int unsigned k = 0; k < held; k++) begin
               if (history[k] > v) greater++;
               else if (history[k] == v) dup_seen = 1'b1;
            end
            inversion_sum += INV_CNT_W'(greater);
            history[held] = v;
            held++;
         end else begin
            ovf_seen = 1'b1;
         end
         if (last) begin
            exp_v.sortable   = dup_seen || !inversion_sum[0];
            exp_v.inversions = inversion_sum;
            exp_v.duplicate  = dup_seen;
            exp_v.overflowed = ovf_seen;
            verdict_q.push_back(exp_v);
            held          = 0;
            inversion_sum = '0;
            dup_seen      = 1'b0;
            ovf_seen      = 1'b0;
         end
      endfunction

      function void check_response(sort_verdict_type got);
         sort_verdict_type exp_v;
         responses++;
         if (verdict_q.size() == 0) begin
            $error("response with no sequence outstanding");
            errors++;
            return;
         end
         exp_v = verdict_q.pop_front();
         if (got.sortable !== exp_v.sortable) begin
            $error("rsp_sortable: expected %0d, got %0d", exp_v.sortable, got.sortable);
            errors++;
         end
         if (got.inversions !== exp_v.inversions) begin
            $error("rsp_inversion_count: expected %0d, got %0d",
                   exp_v.inversions, got.inversions);
            errors++;
         end
         if (got.duplicate !== exp_v.duplicate) begin
            $error("rsp_has_duplicate: expected %0d, got %0d", exp_v.duplicate, got.duplicate);
            errors++;
         end
         if (got.overflowed !== exp_v.overflowed) begin
            $error("rsp_overflowed: expected %0d, got %0d", exp_v.overflowed, got.overflowed);
            errors++;
         end
         if (exp_v.duplicate) dup_runs++;
      endfunction
   endclass

   logic                        clock         = 1'b0;
   logic                        reset         = 1'b1;
   logic                        req_valid     = 1'b0;
   logic                        req_stall;
   logic signed [VALUE_W-1:0]   req_value     = '0;
   logic                        req_last_item = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall     = 1'b0;
   logic                        rsp_sortable;
   logic [INV_CNT_W-1:0]        rsp_inversion_count;
   logic                        rsp_has_duplicate;
   logic                        rsp_overflowed;

   parity_scoreboard sb = new();
   sort_verdict_type seen_verdict;
   int               gap_pct = 0;
   int               stall_pct = 0;
   int unsigned      requests_sent = 0;
   int               directed_q [$];

   inversion_parity_with_duplicates_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_value           (req_value),
      .req_last_item       (req_last_item),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sortable        (rsp_sortable),
      .rsp_inversion_count (rsp_inversion_count),
      .rsp_has_duplicate   (rsp_has_duplicate),
      .rsp_overflowed      (rsp_overflowed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_value, req_last_item);
         if (rsp_valid && !rsp_stall) begin
            seen_verdict = {rsp_sortable, rsp_inversion_count, rsp_has_duplicate,
                            rsp_overflowed};
            sb.check_response(seen_verdict);
         end
      end
   end

   // receiver back-pressure bursts
   initial begin
      forever begin
         @(negedge clock);
         if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic int pick_value(value_style_type style, int unsigned idx);
      case (style)
         DENSE:      return int'($urandom_range(0, 15)) - 8;
         EXTREME: begin
            case ($urandom_range(0, 4))
               0:       return VAL_MIN;
               1:       return VAL_MAX;
               2:       return -1;
               3:       return 0;
               default: return 1;
            endcase
         end
         ASCENDING:  return int'(idx) * 3 - 1000;
         DESCENDING: return 1000 - int'(idx) * 3;
         default:    return int'($urandom());
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(int v, bit last);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_value     <= v;
      req_last_item <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_list(int vals[$]);
      foreach (vals[i]) send_request(vals[i], i == vals.size() - 1);
   endtask

   task automatic send_sequence(int unsigned len, value_style_type style);
      value_style_type s;
      for (int unsigned i = 0; i < len; i++) begin
         s = (style == MIXED) ? value_style_type'($urandom_range(int'(FULL_RANGE),
                                                                 int'(DESCENDING))) : style;
         send_request(pick_value(s, i), i == len - 1);
      end
   endtask

   initial begin
      int unsigned  target;
      int unsigned  len;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, signed order, single element, duplicates
      directed_q = '{VAL_MIN};
      send_list(directed_q);
      directed_q = '{VAL_MAX};
      send_list(directed_q);
      directed_q = '{VAL_MAX, VAL_MIN};
      send_list(directed_q);
      directed_q = '{VAL_MIN, VAL_MAX};
      send_list(directed_q);
      directed_q = '{0, -1};
      send_list(directed_q);
      directed_q = '{-1, -1};
      send_list(directed_q);
      directed_q = '{5, 3, 5};
      send_list(directed_q);
      directed_q = '{32'sh5555_5555, 32'shaaaa_aaaa, VAL_MAX, VAL_MIN, 0, -1};
      send_list(directed_q);
      directed_q = '{3, 2, 1, 0, -1};
      send_list(directed_q);

      target = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < target) begin
         if (requests_sent + QUIET_REQUESTS >= target) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0:       gap_pct = 0;
               1:       gap_pct = 5;
               default: gap_pct = 30;
            endcase
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 5;
               default: stall_pct = 30;
            endcase
         end
         case ($urandom_range(0, 19))
            0:          len = $urandom_range(65, 200);
            1, 2, 3:    len = $urandom_range(17, 64);
            default:    len = $urandom_range(1, 16);
         endcase
         send_sequence(len, value_style_type'($urandom_range(int'(FULL_RANGE), int'(MIXED))));
      end
      req_valid <= 1'b0;

      while (sb.verdict_q.size() != 0) @(posedge clock);
      repeat (MAX_ITEMS + 16) @(posedge clock);

      $display("Ran %0d requests in %0d sequences, from single values to runs of a few hundred;",
               sb.requests, sb.responses);
      $display("%0d sequences held equal values, with signed extremes and receiver stalls.",
               sb.dup_runs);
      if (sb.errors == 0) begin
         $display("PASS inversion_parity_with_duplicates_top");
      end else begin
         $display("FAIL inversion_parity_with_duplicates_top");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL inversion_parity_with_duplicates_top");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/ipd_pkg.sv
sv/ipd_cell.sv
sv/ipd_tail.sv
sv/inversion_parity_with_duplicates_top.sv
sim/inversion_parity_with_duplicates_top_tb.sv
